### src/b64enc_pkg.sv
// ----------------------------------------------------------------------------
// b64enc_pkg
// shared types, constants and the alphabet lookup for the base64 encoder
// ----------------------------------------------------------------------------
package b64enc_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [7:0] PAD_CHAR   = 8'h3D;  // '='
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;  // '+'
    localparam logic [7:0] SLASH_CHAR = 8'h2F;  // '/'
    localparam logic [7:0] UPPER_A    = 8'h41;
    localparam logic [7:0] LOWER_A    = 8'h61;
    localparam logic [7:0] DIGIT_0    = 8'h30;

    // how a group of 24 bits ends up on the wire
    typedef enum logic [1:0] {
        GRP_FULL = 2'd0,  // four data characters
        GRP_PAD1 = 2'd1,  // three data characters and one pad
        GRP_PAD2 = 2'd2   // two data characters and two pads
    } t_grp_kind;

    typedef struct packed {
        logic [23:0] bits;
        t_grp_kind   kind;
        logic        fin;
    } t_group;

    // queue status seen by the front and back parts
    typedef struct packed {
        logic not_empty;
        logic full;
    } t_q_stat;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] ext;
        logic [7:0] res;
        ext = {2'b00, v};
        if (v < 6'd26) begin
            res = UPPER_A + ext;
        end else if (v < 6'd52) begin
            res = LOWER_A + ext - 8'd26;
        end else if (v < 6'd62) begin
            res = DIGIT_0 + ext - 8'd52;
        end else if (v == 6'd62) begin
            res = PLUS_CHAR;
        end else begin
            res = SLASH_CHAR;
        end
        return res;
    endfunction

endpackage

### src/b64enc_if.sv
// ----------------------------------------------------------------------------
// b64enc interfaces
// valid/ready channels for input bytes and output characters
// ----------------------------------------------------------------------------
interface b64enc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64enc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

### src/b64enc_front.sv
// ----------------------------------------------------------------------------
// b64enc_front
// collects bytes into groups of three and pushes finished groups to the queue
// ----------------------------------------------------------------------------
module b64enc_front
    import b64enc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_data_byte,
    input  logic          i_final_byte,
    input  t_q_stat       i_q_stat,
    output logic          o_push,
    output t_group        o_group
);

    logic [15:0] r_pend, n_pend;
    logic [1:0]  r_cnt,  n_cnt;
    logic        accept;
    logic        emit;

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && emit;

    always_comb begin
        n_pend        = r_pend;
        n_cnt         = r_cnt;
        emit          = 1'b1;
        o_group.bits  = {r_pend, i_data_byte};
        o_group.kind  = GRP_FULL;
        o_group.fin   = i_final_byte;
        case (r_cnt)
            2'd0: begin
                o_group.bits = {i_data_byte, 16'h0000};
                o_group.kind = GRP_PAD2;
                o_group.fin  = 1'b1;
                emit         = i_final_byte;
            end
            2'd1: begin
                o_group.bits = {r_pend[7:0], i_data_byte, 8'h00};
                o_group.kind = GRP_PAD1;
                o_group.fin  = 1'b1;
                emit         = i_final_byte;
            end
            default: begin
                // two held (or the unreachable three): group completes
                emit = 1'b1;
            end
        endcase
        if (accept) begin
            if (emit) begin
                n_pend = 16'h0000;
                n_cnt  = 2'd0;
            end else begin
                n_pend = {r_pend[7:0], i_data_byte};
                n_cnt  = r_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 16'h0000;
            r_cnt  <= 2'd0;
        end else begin
            r_pend <= n_pend;
            r_cnt  <= n_cnt;
        end
    end

endmodule

### src/b64enc_queue.sv
// ----------------------------------------------------------------------------
// b64enc_queue
// two-entry group queue between the byte collector and the serializer
// ----------------------------------------------------------------------------
module b64enc_queue
    import b64enc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_group  i_group,
    input  logic    i_pop,
    output t_group  o_group,
    output t_q_stat o_stat
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_group             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_cnt,    n_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_stat.not_empty = (r_cnt != '0);
    assign o_stat.full      = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_group          = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && o_stat.not_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

endmodule

### src/b64enc_back.sv
// ----------------------------------------------------------------------------
// b64enc_back
// turns one queued group into four characters through a registered output
// ----------------------------------------------------------------------------
module b64enc_back
    import b64enc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_stat    i_q_stat,
    input  t_group     i_group,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic       o_last_char
);

    t_group      r_cur;
    logic        r_busy,  n_busy;
    logic [1:0]  r_idx,   n_idx;
    logic        r_ovld,  n_ovld;
    logic [7:0]  r_char;
    logic        r_last;
    logic        can_emit;
    logic        done;
    logic [5:0]  sext;
    logic        is_pad;
    logic [7:0]  ch;
    logic        ch_last;

    assign can_emit = r_busy && (!r_ovld || i_ready);
    assign done     = can_emit && (r_idx == 2'd3);
    assign o_pop    = i_q_stat.not_empty && (!r_busy || done);

    always_comb begin
        case (r_idx)
            2'd0:    sext = r_cur.bits[23:18];
            2'd1:    sext = r_cur.bits[17:12];
            2'd2:    sext = r_cur.bits[11:6];
            default: sext = r_cur.bits[5:0];
        endcase
        is_pad  = ((r_cur.kind == GRP_PAD2) && r_idx[1])
               || ((r_cur.kind == GRP_PAD1) && (r_idx == 2'd3));
        ch      = is_pad ? PAD_CHAR : b64_char(sext);
        ch_last = (r_idx == 2'd3) && r_cur.fin;
    end

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        n_ovld = r_ovld;
        if (can_emit) begin
            n_ovld = 1'b1;
            n_idx  = r_idx + 2'd1;
        end else if (i_ready) begin
            n_ovld = 1'b0;
        end
        if (o_pop) begin
            n_busy = 1'b1;
            n_idx  = 2'd0;
        end else if (done) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_group;
        end
        if (can_emit) begin
            r_char <= ch;
            r_last <= ch_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
            r_ovld <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
            r_ovld <= n_ovld;
        end
    end

    assign o_valid     = r_ovld;
    assign o_out_char  = r_char;
    assign o_last_char = r_last;

endmodule

### src/base64_stream_encoder.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder
// byte stream in, standard base64 characters out
// ----------------------------------------------------------------------------
// input channel i_in carries one message byte per transfer; final_byte marks
// the last byte of a message. output channel o_out carries one ascii character
// per transfer; last_char marks the final character of the message.
// every third byte, or a final byte, forms a group that becomes four
// characters; a short final group is zero filled and padded with '='.
// a closing byte's group passes through a queue entry, the serializer's group
// register and the output register before its first character is valid.
// throughput: the serializer sends one character per cycle while the receiver
// is ready; the sustained byte rate is set by the one-character output port.
// a two-entry group queue lets the byte side keep going while the serializer
// drains. reset clears the held bytes, the queue and the output valid flag.
// when the receiver stalls the output register holds its character, the
// queue fills, and i_in.ready drops once both queue entries are occupied.
// ----------------------------------------------------------------------------
module base64_stream_encoder
    import b64enc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    b64enc_byte_if.sink         i_in,
    b64enc_char_if.source       o_out
);

    t_q_stat q_stat;
    t_group  push_group;
    t_group  head_group;
    logic    push;
    logic    pop;

    b64enc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in.valid),
        .o_ready      (i_in.ready),
        .i_data_byte  (i_in.data_byte),
        .i_final_byte (i_in.final_byte),
        .i_q_stat     (q_stat),
        .o_push       (push),
        .o_group      (push_group)
    );

    b64enc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_group (push_group),
        .i_pop   (pop),
        .o_group (head_group),
        .o_stat  (q_stat)
    );

    b64enc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_group     (head_group),
        .o_pop       (pop),
        .o_valid     (o_out.valid),
        .i_ready     (o_out.ready),
        .o_out_char  (o_out.out_char),
        .o_last_char (o_out.last_char)
    );

endmodule

### tb/sv/base64_stream_encoder_checker.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder_checker
// watches both channels, predicts the character stream and compares it
// ----------------------------------------------------------------------------
// every byte transfer runs through a bit-level model of the encoder that keeps
// its own copy of the held bytes and their count. the characters it predicts
// wait in order until the matching character transfers; out_char and
// last_char are checked one by one. the failure count and the number of
// characters still expected go back to the testbench top.
// ----------------------------------------------------------------------------
module base64_stream_encoder_checker
    import b64enc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    b64enc_byte_if      i_bytes,
    b64enc_char_if      i_chars,
    output int          o_fail_count,
    output int          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // sextet value 0 selects the leftmost character
    localparam logic [511:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_b64_char;

    t_b64_char   expected_chars[$];
    t_b64_char   oldest;
    logic [15:0] held_bytes = '0;
    logic [1:0]  held_count = '0;
    int          fail_total = 0;

    task automatic predict_chars(input logic [7:0] b, input logic fin);
        logic [23:0] grp;
        t_grp_kind   kind;
        int          pads;
        logic [5:0]  six;
        t_b64_char   item;
        if (held_count == 2'd0 && !fin) begin
            held_bytes = {8'h00, b};
            held_count = 2'd1;
        end else if (held_count == 2'd1 && !fin) begin
            held_bytes = {held_bytes[7:0], b};
            held_count = 2'd2;
        end else begin
            case (held_count)
                2'd0: begin
                    grp  = {b, 16'h0000};
                    kind = GRP_PAD2;
                end
                2'd1: begin
                    grp  = {held_bytes[7:0], b, 8'h00};
                    kind = GRP_PAD1;
                end
                // a count of three is handled as two
                default: begin
                    grp  = {held_bytes, b};
                    kind = GRP_FULL;
                end
            endcase
            pads = (kind == GRP_PAD2) ? 2 : (kind == GRP_PAD1) ? 1 : 0;
            for (int i = 0; i < 4; i++) begin
                six       = grp[23 - 6 * i -: 6];
                item.ch   = (i >= 4 - pads) ? PAD_CHAR
                                            : B64_ALPHABET[8 * (63 - int'(six)) +: 8];
                item.last = (i == 3) && fin;
                expected_chars.insert(expected_chars.size(), item);
            end
            held_bytes = '0;
            held_count = '0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_bytes = '0;
            held_count = '0;
            expected_chars.delete();
        end else begin
            if (i_bytes.valid && i_bytes.ready) begin
                predict_chars(i_bytes.data_byte, i_bytes.final_byte);
            end
            if (i_chars.valid && i_chars.ready) begin
                if (expected_chars.size() == 0) begin
                    $error("out_char: expected none, actual %h", i_chars.out_char);
                    fail_total++;
                end else begin
                    oldest = expected_chars.pop_front();
                    if (i_chars.out_char !== oldest.ch) begin
                        $error("out_char: expected %h, actual %h",
                               oldest.ch, i_chars.out_char);
                        fail_total++;
                    end
                    if (i_chars.last_char !== oldest.last) begin
                        $error("last_char: expected %b, actual %b",
                               oldest.last, i_chars.last_char);
                        fail_total++;
                    end
                end
            end
        end
        o_fail_count  <= fail_total;
        o_outstanding <= expected_chars.size();
    end

endmodule

### tb/sv/base64_stream_encoder_tb.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder_tb
// stimulus and verdict for the base64 stream encoder
// ----------------------------------------------------------------------------
// a short directed run covers one- and two-byte tails, full groups with and
// without the final flag, the extreme byte values and the '+' and '/'
// characters. random messages of mostly short length follow. both sides
// idle at random, one stretch runs with no idling, and once the receiver
// holds off long enough for the encoder to back up into the byte side.
// ----------------------------------------------------------------------------
module base64_stream_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 150;
    localparam int HOLD_AT_ITEM   = 40;
    localparam int HOLD_CYCLES    = 120;
    localparam int BURST_FIRST    = 90;
    localparam int BURST_LAST     = 120;
    localparam int DRAIN_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 1000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   check_failures;
    int   chars_outstanding;
    int   random_sent;
    bit   no_idle;
    int   idle_cycles = 0;

    b64enc_byte_if byte_bus ();
    b64enc_char_if char_bus ();

    base64_stream_encoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_bus),
        .o_out   (char_bus)
    );

    base64_stream_encoder_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_bytes       (byte_bus),
        .i_chars       (char_bus),
        .o_fail_count  (check_failures),
        .o_outstanding (chars_outstanding)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // mostly no gap, some short ones, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic int message_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) begin
            return $urandom_range(1, 3);
        end else if (r < 9) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(13, 40);
    endfunction

    function automatic logic [7:0] random_byte();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) begin
            return 8'h00;
        end else if (r == 1) begin
            return 8'hFF;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = no_idle ? 0 : idle_len();
        if (gap > 0) begin
            byte_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        byte_bus.valid      <= 1'b1;
        byte_bus.data_byte  <= b;
        byte_bus.final_byte <= fin;
        @(posedge i_clk);
        while (!byte_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin : receiver
        int   stall_left;
        int   hold_left;
        bit   hold_done;
        logic rdy;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        char_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            // one long hold-off while the sender keeps offering bytes
            if (!hold_done && random_sent >= HOLD_AT_ITEM) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                rdy = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                rdy = 1'b0;
                stall_left--;
            end else if (no_idle) begin
                rdy = 1'b1;
            end else begin
                stall_left = ($urandom_range(0, 3) == 0) ? idle_len() : 0;
                if (stall_left > 0) begin
                    rdy = 1'b0;
                    stall_left--;
                end else begin
                    rdy = 1'b1;
                end
            end
            char_bus.ready <= rdy;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (byte_bus.valid && byte_bus.ready)
                     || (char_bus.valid && char_bus.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int msg_len;
        byte_bus.valid      = 1'b0;
        byte_bus.data_byte  = 8'h00;
        byte_bus.final_byte = 1'b0;
        i_rst_n     = 1'b0;
        random_sent = 0;
        no_idle     = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // single-byte tails: "AA==" and "/w=="
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        // two-byte tails: "//8=" and "AAA="
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        // full group closed by the final byte, no padding
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        // "++++" then a fresh group inside the same message
        send_byte(8'hFB, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBE, 1'b0);
        send_byte(8'h80, 1'b1);
        // zero group, then a two-byte tail
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h01, 1'b1);
        // "ABCD" then a one-byte tail
        send_byte(8'h00, 1'b0);
        send_byte(8'h10, 1'b0);
        send_byte(8'h83, 1'b0);
        send_byte(8'h55, 1'b1);

        while (random_sent < RANDOM_ITEMS) begin
            msg_len = message_len();
            for (int k = 0; k < msg_len; k++) begin
                send_byte(random_byte(), k == msg_len - 1);
                random_sent++;
                no_idle = (random_sent >= BURST_FIRST) && (random_sent < BURST_LAST);
            end
        end
        byte_bus.valid <= 1'b0;

        while (chars_outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (check_failures == 0 && chars_outstanding == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
